### src/slcfr_pkg.sv
// Shared types and constants for the sync/length/CRC-8 frame receiver.
`default_nettype none
package slcfr_pkg;

   localparam logic [7:0]  FRAME_START       = 8'hA7;
   localparam logic [15:0] HDR_TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] DAT_TIMEOUT_RESET = 16'd1000;
   localparam logic [7:0]  CRC_POLY_RESET    = 8'h07;
   localparam logic [7:0]  CRC_INIT_RESET    = 8'h00;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [1:0] {
      PH_SYNC,
      PH_HEADER,
      PH_DATA,
      PH_CRC
   } phase_type;

   typedef enum logic [1:0] {
      EV_PAYLOAD,
      EV_FRAME_GOOD,
      EV_CRC_BAD,
      EV_TIMEOUT
   } event_type;

   typedef enum logic [1:0] {
      CSR_HDR_TIMEOUT,
      CSR_DAT_TIMEOUT,
      CSR_CRC_POLY,
      CSR_CRC_INIT
   } csr_index_type;

   typedef struct packed {
      event_type   ev;
      logic [7:0]  address;
      logic [7:0]  command;
      logic [15:0] length;
      logic [7:0]  pbyte;
      logic [15:0] pindex;
      logic        last;
   } result_type;

endpackage : slcfr_pkg
`default_nettype wire

### src/slcfr_crc8.sv
// Byte-wide CRC-8 update, MSB first, programmable polynomial.
`default_nettype none
module slcfr_crc8
   import slcfr_pkg::*;
(
   input  wire logic [7:0] crc_in,
   input  wire logic [7:0] data_in,
   input  wire logic [7:0] poly,
   output logic      [7:0] crc_out
);

   always_comb begin
      logic [7:0] c;
      c = crc_in ^ data_in;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      crc_out = c;
   end

endmodule : slcfr_crc8
`default_nettype wire

### src/sync_length_crc_frame_receiver.sv
// A byte passes the input register and then the result register before rsp_tvalid rises.
// Throughput: one item per cycle while no result is blocked; frame state and CRC update for a byte are combinational.
// An input item is taken while a result still waits, held in the input register until the result moves.
// Reset (synchronous, active high): hunt for sync, clear frame state, load register defaults.
// No memories, so no clearing pass after reset.
`default_nettype none
module sync_length_crc_frame_receiver
   import slcfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_value
   input  wire logic        req_tuser,   // [0] cmd
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [7:0] device_address, [15:8] command_code,
                                         // [31:16] payload_length, [39:32] payload_byte,
                                         // [55:40] payload_index
   output logic [1:0]       rsp_tuser,   // [1:0] event_res
   output logic             rsp_tlast,   // last
   // configuration
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // configuration registers
   logic [15:0] hdr_limit_ff;
   logic [15:0] dat_limit_ff;
   logic [7:0]  crc_poly_ff;
   logic [7:0]  crc_init_ff;

   // input register
   logic        in_valid_ff;
   logic        in_cmd_ff;
   logic [7:0]  in_byte_ff;

   // frame state
   phase_type   phase_ff, phase_in;
   logic [1:0]  header_count_ff, header_count_in;
   logic [7:0]  frame_address_ff, frame_address_in;
   logic [7:0]  frame_command_ff, frame_command_in;
   logic [15:0] frame_length_ff, frame_length_in;
   logic [15:0] data_count_ff, data_count_in;
   logic [7:0]  running_crc_ff, running_crc_in;
   logic [15:0] phase_timer_ff, phase_timer_in;

   // result register
   logic        rsp_valid_ff;
   result_type  rsp_ff, rsp_in;

   logic        is_tick;
   logic        has_result;
   logic        advance;
   logic        timed_out;
   logic        last_byte;
   logic [15:0] timer_inc;
   logic [15:0] limit;
   logic [16:0] count_next;
   logic [15:0] length_hdr;
   logic [7:0]  crc_fed;

   slcfr_crc8 u_crc8 (
      .crc_in  (running_crc_ff),
      .data_in (in_byte_ff),
      .poly    (crc_poly_ff),
      .crc_out (crc_fed)
   );

   assign is_tick    = (in_cmd_ff == CMD_TICK);
   assign limit      = (phase_ff == PH_HEADER) ? hdr_limit_ff : dat_limit_ff;
   assign timer_inc  = (phase_timer_ff == 16'hFFFF) ? phase_timer_ff : phase_timer_ff + 16'd1;
   // a zero limit trips on the first tick, same as one
   assign timed_out  = (timer_inc >= limit);
   assign count_next = {1'b0, data_count_ff} + 17'd1;
   assign last_byte  = (count_next == {1'b0, frame_length_ff});
   assign length_hdr = {in_byte_ff, frame_length_ff[7:0]};

   always_comb begin
      if (is_tick) begin
         has_result = (phase_ff != PH_SYNC) && timed_out;
      end else begin
         has_result = (phase_ff == PH_DATA) || (phase_ff == PH_CRC);
      end
   end

   // an item with no result never waits on the result register
   assign advance    = in_valid_ff && (!has_result || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_tick) begin
         if ((phase_ff != PH_SYNC) && timed_out) begin
            phase_in = PH_SYNC;
         end
      end else begin
         case (phase_ff)
            PH_SYNC: begin
               if (in_byte_ff == FRAME_START) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_HEADER: begin
               if (header_count_ff == 2'd3) begin
                  phase_in = (length_hdr == 16'd0) ? PH_CRC : PH_DATA;
               end
            end
            PH_DATA: begin
               if (last_byte) begin
                  phase_in = PH_CRC;
               end
            end
            PH_CRC:  phase_in = PH_SYNC;
            default: phase_in = PH_SYNC;
         endcase
      end
   end

   // frame datapath and result
   always_comb begin
      header_count_in  = header_count_ff;
      frame_address_in = frame_address_ff;
      frame_command_in = frame_command_ff;
      frame_length_in  = frame_length_ff;
      data_count_in    = data_count_ff;
      running_crc_in   = running_crc_ff;
      phase_timer_in   = phase_timer_ff;

      rsp_in.ev      = EV_TIMEOUT;
      rsp_in.address = frame_address_ff;
      rsp_in.command = frame_command_ff;
      rsp_in.length  = frame_length_ff;
      rsp_in.pbyte   = 8'd0;
      rsp_in.pindex  = 16'd0;
      rsp_in.last    = 1'b0;

      if (is_tick) begin
         if (phase_ff != PH_SYNC) begin
            phase_timer_in = timed_out ? 16'd0 : timer_inc;
         end
      end else begin
         case (phase_ff)
            PH_SYNC: begin
               if (in_byte_ff == FRAME_START) begin
                  header_count_in = 2'd0;
                  data_count_in   = 16'd0;
                  running_crc_in  = crc_init_ff;
                  phase_timer_in  = 16'd0;
               end
            end
            PH_HEADER: begin
               running_crc_in = crc_fed;
               case (header_count_ff)
                  2'd0:    frame_address_in = in_byte_ff;
                  2'd1:    frame_command_in = in_byte_ff;
                  2'd2:    frame_length_in  = {frame_length_ff[15:8], in_byte_ff};
                  default: frame_length_in  = length_hdr;
               endcase
               if (header_count_ff == 2'd3) begin
                  header_count_in = 2'd0;
                  data_count_in   = 16'd0;
                  phase_timer_in  = 16'd0;
               end else begin
                  header_count_in = header_count_ff + 2'd1;
               end
            end
            PH_DATA: begin
               running_crc_in = crc_fed;
               data_count_in  = count_next[15:0];
               rsp_in.ev      = EV_PAYLOAD;
               rsp_in.pbyte   = in_byte_ff;
               rsp_in.pindex  = data_count_ff;
               rsp_in.last    = last_byte;
               if (last_byte) begin
                  phase_timer_in = 16'd0;
               end
            end
            default: begin
               rsp_in.ev      = (in_byte_ff == running_crc_ff) ? EV_FRAME_GOOD : EV_CRC_BAD;
               phase_timer_in = 16'd0;
            end
         endcase
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_limit_ff <= HDR_TIMEOUT_RESET;
         dat_limit_ff <= DAT_TIMEOUT_RESET;
         crc_poly_ff  <= CRC_POLY_RESET;
         crc_init_ff  <= CRC_INIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HDR_TIMEOUT: hdr_limit_ff <= csr_wdata;
            CSR_DAT_TIMEOUT: dat_limit_ff <= csr_wdata;
            CSR_CRC_POLY:    crc_poly_ff  <= csr_wdata[7:0];
            CSR_CRC_INIT:    crc_init_ff  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SYNC;
         header_count_ff  <= 2'd0;
         frame_address_ff <= 8'd0;
         frame_command_ff <= 8'd0;
         frame_length_ff  <= 16'd0;
         data_count_ff    <= 16'd0;
         running_crc_ff   <= CRC_INIT_RESET;
         phase_timer_ff   <= 16'd0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         header_count_ff  <= header_count_in;
         frame_address_ff <= frame_address_in;
         frame_command_ff <= frame_command_in;
         frame_length_ff  <= frame_length_in;
         data_count_ff    <= data_count_in;
         running_crc_ff   <= running_crc_in;
         phase_timer_ff   <= phase_timer_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.ev;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {rsp_ff.pindex, rsp_ff.pbyte, rsp_ff.length,
                        rsp_ff.command, rsp_ff.address};

`ifndef SYNTHESIS
   a_sync_timer_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SYNC) |-> (phase_timer_ff == 16'd0))
      else $error("phase timer running while hunting for sync");

   a_data_count_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (data_count_ff < frame_length_ff))
      else $error("payload count past frame length");

   a_held_item_stable: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_cmd_ff)))
      else $error("stalled input item lost or changed");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> (has_result && rsp_valid_ff && !rsp_tready))
      else $error("input item stalled without a blocked result");
`endif

endmodule : sync_length_crc_frame_receiver
`default_nettype wire
